// File: rtl/dual_motor_pid_speed_control_top_assert.svh
// assertion macros for the speed controller rtl
// no dependencies; files that check their logic include this header
`ifndef DUAL_MOTOR_PID_SPEED_CONTROL_TOP_ASSERT_SVH
`define DUAL_MOTOR_PID_SPEED_CONTROL_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// check a property outside reset
`define DMPSC_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("dmpsc assertion failed");
// check a property at every edge, reset included
`define DMPSC_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("dmpsc assertion failed");
`else
`define DMPSC_ASSERT(name, clk, rst_n, prop)
`define DMPSC_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

// File: rtl/dmpsc_pkg.sv
// shared types, constants and helpers of the dual motor pid speed controller
// no dependencies; used by every rtl module of the block
`default_nettype none

package dmpsc_pkg;

    // duty full scale default
    localparam int DUTY_FULL_SCALE_DEF = 1023;

    // field widths
    localparam int DUTY_W   = 10;
    localparam int RPM_W    = 8;
    localparam int GAIN_W   = 8;
    localparam int CFG_A_W  = 3;
    localparam int CFG_D_W  = 10;
    localparam int MUL_W    = 16;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 24;
    // width of target_setpoint * 100
    localparam int SP_PROD_W = 17;

    // register indexes of the configuration port
    localparam logic [CFG_A_W-1:0] CFG_TARGET_SETPOINT   = 3'd0;
    localparam logic [CFG_A_W-1:0] CFG_GAIN_P            = 3'd1;
    localparam logic [CFG_A_W-1:0] CFG_GAIN_I            = 3'd2;
    localparam logic [CFG_A_W-1:0] CFG_GAIN_D            = 3'd3;
    localparam logic [CFG_A_W-1:0] CFG_DRIVE_ENABLE      = 3'd4;
    localparam logic [CFG_A_W-1:0] CFG_LEFT_DIR_FORWARD  = 3'd5;
    localparam logic [CFG_A_W-1:0] CFG_RIGHT_DIR_FORWARD = 3'd6;

    // register reset values
    localparam logic [DUTY_W-1:0] RST_TARGET_SETPOINT = 10'd612;
    localparam logic [GAIN_W-1:0] RST_GAIN_P          = 8'd3;
    localparam logic [GAIN_W-1:0] RST_GAIN_I          = 8'd2;
    localparam logic [GAIN_W-1:0] RST_GAIN_D          = 8'd2;

    // arithmetic constants
    localparam logic [MUL_W-1:0] RPM_SCALE   = 16'd100;
    localparam logic [RPM_W-1:0] RPM_OFFSET  = 8'd4;
    localparam logic [RPM_W-1:0] TERM_LIMIT  = 8'd70;
    // x/10 == (x*0xcccd) >> 19 for any 16-bit x
    localparam logic [MUL_W-1:0] RECIP10_W   = 16'hcccd;
    // x/10 == (x*205) >> 11 for any 8-bit x
    localparam logic [MUL_W-1:0] RECIP10_N   = 16'd205;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_DIV_SP,
        ST_TARGET,
        ST_ERR,
        ST_P,
        ST_D,
        ST_IMUL,
        ST_I,
        ST_SUM,
        ST_WMUL,
        ST_DIV_OUT,
        ST_DUTY,
        ST_EMIT
    } ctrl_state_t;

    // datapath operations
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_SCALE,
        DP_DIV_SP,
        DP_TARGET,
        DP_ERR,
        DP_P,
        DP_D,
        DP_IMUL,
        DP_I,
        DP_SUM,
        DP_WMUL,
        DP_DIV_OUT,
        DP_DUTY,
        DP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   motor;
    } dp_cmd_t;

    typedef struct packed {
        logic run;
    } dp_status_t;

    // keep a term only when strictly between 0 and the limit
    function automatic logic [RPM_W-1:0] gate_term(input logic [RPM_W-1:0] t);
        logic keep;
        keep = !t[RPM_W-1] && (t != '0) && (t < TERM_LIMIT);
        return keep ? t : '0;
    endfunction

endpackage

`default_nettype wire

// File: rtl/dmpsc_div.sv
// divider by a constant through reciprocal multiplication, quotient registered on start
// depends on dmpsc_pkg for its parameter defaults
`default_nettype none

module dmpsc_div #(
    parameter int DIVIDEND_W = dmpsc_pkg::SP_PROD_W,
    parameter int DIVISOR    = dmpsc_pkg::DUTY_FULL_SCALE_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    output logic [DIVIDEND_W-1:0]      quotient
);

    // floor(x/d) == (x*m) >> s, with s = dividend bits + ceil(log2 d) and m = ceil(2^s/d)
    localparam int                 SHIFT   = DIVIDEND_W + $clog2(DIVISOR);
    localparam int                 RECIP_W = DIVIDEND_W + 1;
    localparam int                 PROD_W  = DIVIDEND_W + RECIP_W;
    localparam logic [63:0]        POW     = 64'd1 << SHIFT;
    localparam logic [63:0]        DSR     = 64'(DIVISOR);
    localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'((POW + DSR - 64'd1) / DSR);

    logic [PROD_W-1:0]     prod;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;

    // multiply by the reciprocal and drop the fraction bits
    always_comb begin
        prod     = PROD_W'(dividend) * PROD_W'(RECIP);
        quo_next = start ? DIVIDEND_W'(prod >> SHIFT) : quo_reg;
    end

    // quotient register
    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;

endmodule

`default_nettype wire

// File: rtl/dmpsc_dp.sv
// datapath: configuration registers, per-motor state, shared multiplier,
// constant dividers and output register; depends on dmpsc_pkg and dmpsc_div
`default_nettype none

module dmpsc_dp #(
    parameter int DUTY_FULL_SCALE = dmpsc_pkg::DUTY_FULL_SCALE_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire dmpsc_pkg::dp_cmd_t             cmd,
    output dmpsc_pkg::dp_status_t               status,
    input  wire logic                           s_cmd,
    input  wire logic [dmpsc_pkg::S_DATA_W-1:0] s_data,
    output logic [dmpsc_pkg::M_DATA_W-1:0]      m_data,
    input  wire logic                           cfg_we,
    input  wire logic [dmpsc_pkg::CFG_A_W-1:0]  cfg_addr,
    input  wire logic [dmpsc_pkg::CFG_D_W-1:0]  cfg_wdata
);
    import dmpsc_pkg::*;

    localparam int DFS_W  = $clog2(DUTY_FULL_SCALE + 1);
    localparam int WIDE_W = RPM_W + DFS_W;
    localparam logic [MUL_W-1:0]  DFS_M = MUL_W'(DUTY_FULL_SCALE);
    localparam logic [WIDE_W-1:0] DFS_Q = WIDE_W'(DUTY_FULL_SCALE);

    // configuration
    logic [DUTY_W-1:0] ts_reg;
    logic [GAIN_W-1:0] gp_reg, gi_reg, gd_reg;
    logic              en_reg, ldir_reg, rdir_reg;

    // per-motor state and item payload
    logic [RPM_W-1:0]  last_err_reg [2];
    logic [RPM_W-1:0]  err_sum_reg  [2];
    logic [RPM_W-1:0]  meas_reg     [2];
    logic [DUTY_W-1:0] duty_reg     [2];
    logic              run_reg;

    // working registers
    logic [RPM_W-1:0]    target_reg, err_reg, der_reg, sum_reg;
    logic [RPM_W-1:0]    tp_reg, ti_reg, td_reg, vrpm_reg;
    logic [2*MUL_W-1:0]  prod_reg;
    logic [M_DATA_W-1:0] out_reg;

    // shared multiplier
    logic [MUL_W-1:0]   mul_a, mul_b;
    logic [2*MUL_W-1:0] mul_p;

    // error step logic
    logic [RPM_W-1:0] meas_sel, err_new, der_new, sum_new;
    logic [MUL_W-1:0] tdiv_prod;
    logic [4:0]       tdiv;
    logic             err_low;

    // division results
    logic [SP_PROD_W-1:0] sp_quo;
    logic [WIDE_W-1:0]    wide_quo;
    logic [WIDE_W-1:0]    duty_clamp;

    // configuration write port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ts_reg   <= RST_TARGET_SETPOINT;
            gp_reg   <= RST_GAIN_P;
            gi_reg   <= RST_GAIN_I;
            gd_reg   <= RST_GAIN_D;
            en_reg   <= 1'b1;
            ldir_reg <= 1'b0;
            rdir_reg <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_TARGET_SETPOINT:   ts_reg   <= cfg_wdata;
                CFG_GAIN_P:            gp_reg   <= cfg_wdata[GAIN_W-1:0];
                CFG_GAIN_I:            gi_reg   <= cfg_wdata[GAIN_W-1:0];
                CFG_GAIN_D:            gd_reg   <= cfg_wdata[GAIN_W-1:0];
                CFG_DRIVE_ENABLE:      en_reg   <= cfg_wdata[0];
                CFG_LEFT_DIR_FORWARD:  ldir_reg <= cfg_wdata[0];
                CFG_RIGHT_DIR_FORWARD: rdir_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            DP_SCALE: begin
                mul_a = MUL_W'(ts_reg);
                mul_b = RPM_SCALE;
            end
            DP_P: begin
                mul_a = MUL_W'(err_reg);
                mul_b = MUL_W'(gp_reg);
            end
            DP_D: begin
                mul_a = MUL_W'(der_reg);
                mul_b = MUL_W'(gd_reg);
            end
            DP_IMUL: begin
                mul_a = MUL_W'(sum_reg);
                mul_b = MUL_W'(gi_reg);
            end
            DP_I: begin
                mul_a = prod_reg[MUL_W-1:0];
                mul_b = RECIP10_W;
            end
            DP_WMUL: begin
                mul_a = MUL_W'(vrpm_reg);
                mul_b = DFS_M;
            end
            default: ;
        endcase
        mul_p = mul_a * mul_b;
    end

    // error, derivative and integral update for the selected motor
    always_comb begin
        meas_sel  = meas_reg[cmd.motor];
        err_new   = target_reg - meas_sel;
        der_new   = err_new - last_err_reg[cmd.motor];
        tdiv_prod = MUL_W'(target_reg) * RECIP10_N;
        tdiv      = tdiv_prod[15:11];
        err_low   = err_new[RPM_W-1] || (err_new < RPM_W'(tdiv));
        sum_new   = err_low ? RPM_W'(err_sum_reg[cmd.motor] + err_new) : '0;
    end

    // clamp of the converted duty
    always_comb begin
        duty_clamp = (wide_quo > DFS_Q) ? DFS_Q : wide_quo;
    end

    // setpoint scaled to rpm: divide by the full scale
    dmpsc_div #(
        .DIVIDEND_W (SP_PROD_W),
        .DIVISOR    (DUTY_FULL_SCALE)
    ) u_div_sp (
        .aclk     (aclk),
        .start    (cmd.op == DP_DIV_SP),
        .dividend (prod_reg[SP_PROD_W-1:0]),
        .quotient (sp_quo)
    );

    // rpm converted back to duty: divide by a hundred
    dmpsc_div #(
        .DIVIDEND_W (WIDE_W),
        .DIVISOR    (int'(RPM_SCALE))
    ) u_div_out (
        .aclk     (aclk),
        .start    (cmd.op == DP_DIV_OUT),
        .dividend (prod_reg[WIDE_W-1:0]),
        .quotient (wide_quo)
    );

    // per-motor state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_err_reg[0] <= '0;
            last_err_reg[1] <= '0;
            err_sum_reg[0]  <= '0;
            err_sum_reg[1]  <= '0;
        end else if (cmd.op == DP_ERR) begin
            last_err_reg[cmd.motor] <= err_new;
            err_sum_reg[cmd.motor]  <= sum_new;
        end
    end

    // item payload and working registers
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            DP_LOAD: begin
                run_reg     <= s_cmd;
                meas_reg[0] <= s_data[RPM_W-1:0];
                meas_reg[1] <= s_data[2*RPM_W-1:RPM_W];
            end
            DP_SCALE, DP_IMUL, DP_WMUL: begin
                prod_reg <= mul_p;
            end
            DP_TARGET: begin
                target_reg <= sp_quo[RPM_W-1:0] - RPM_OFFSET;
            end
            DP_ERR: begin
                err_reg <= err_new;
                der_reg <= der_new;
                sum_reg <= sum_new;
            end
            DP_P:   tp_reg <= gate_term(mul_p[RPM_W-1:0]);
            DP_D:   td_reg <= gate_term(mul_p[RPM_W-1:0]);
            DP_I:   ti_reg <= gate_term(mul_p[26:19]);
            DP_SUM: vrpm_reg <= target_reg + tp_reg + ti_reg + td_reg + RPM_OFFSET;
            DP_DUTY: begin
                duty_reg[cmd.motor] <= duty_clamp[DUTY_W-1:0];
            end
            DP_EMIT: begin
                out_reg <= {1'b0, en_reg,
                            rdir_reg, run_reg ? duty_reg[1] : {DUTY_W{1'b0}},
                            ldir_reg, run_reg ? duty_reg[0] : {DUTY_W{1'b0}}};
            end
            default: ;
        endcase
    end

    assign status.run = run_reg;
    assign m_data     = out_reg;

endmodule

`default_nettype wire

// File: rtl/dmpsc_ctrl.sv
// controller: sequences one pid step per motor over the datapath
// depends on dmpsc_pkg and the assertion header
`default_nettype none
`include "dual_motor_pid_speed_control_top_assert.svh"

module dmpsc_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output dmpsc_pkg::dp_cmd_t         cmd,
    input  wire dmpsc_pkg::dp_status_t status
);
    import dmpsc_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        motor_reg, motor_next;
    logic        out_valid_reg, out_valid_next;

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            motor_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            motor_reg     <= motor_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and datapath commands
    always_comb begin
        state_next     = state_reg;
        motor_next     = motor_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd.op         = DP_NOP;
        cmd.motor      = motor_reg;
        s_tready       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = DP_LOAD;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                cmd.op     = DP_SCALE;
                state_next = status.run ? ST_DIV_SP : ST_EMIT;
            end
            ST_DIV_SP: begin
                cmd.op     = DP_DIV_SP;
                state_next = ST_TARGET;
            end
            ST_TARGET: begin
                cmd.op     = DP_TARGET;
                motor_next = 1'b0;
                state_next = ST_ERR;
            end
            ST_ERR: begin
                cmd.op     = DP_ERR;
                state_next = ST_P;
            end
            ST_P: begin
                cmd.op     = DP_P;
                state_next = ST_D;
            end
            ST_D: begin
                cmd.op     = DP_D;
                state_next = ST_IMUL;
            end
            ST_IMUL: begin
                cmd.op     = DP_IMUL;
                state_next = ST_I;
            end
            ST_I: begin
                cmd.op     = DP_I;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.op     = DP_SUM;
                state_next = ST_WMUL;
            end
            ST_WMUL: begin
                cmd.op     = DP_WMUL;
                state_next = ST_DIV_OUT;
            end
            ST_DIV_OUT: begin
                cmd.op     = DP_DIV_OUT;
                state_next = ST_DUTY;
            end
            ST_DUTY: begin
                cmd.op = DP_DUTY;
                if (!motor_reg) begin
                    motor_next = 1'b1;
                    state_next = ST_ERR;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // wait for the output register to free up
                if (!out_valid_reg || m_tready) begin
                    cmd.op         = DP_EMIT;
                    out_valid_next = 1'b1;
                    motor_next     = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_tvalid = out_valid_reg;

    // checks
    `DMPSC_ASSERT(a_emit_no_overwrite, aclk, aresetn, (cmd.op == DP_EMIT) |-> (!out_valid_reg || m_tready))
    `DMPSC_ASSERT(a_accept_starts, aclk, aresetn, (s_tvalid && s_tready) |=> (state_reg == ST_START))
    `DMPSC_ASSERT(a_emit_sets_valid, aclk, aresetn, (cmd.op == DP_EMIT) |=> m_tvalid)
    `DMPSC_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid)

endmodule

`default_nettype wire

// File: rtl/dual_motor_pid_speed_control_top.sv
// top level of the dual motor pid speed controller
// depends on dmpsc_pkg, dmpsc_ctrl, dmpsc_dp and dmpsc_div
//
// channel  direction  payload
// s_       in         tuser: command; tdata: left_speed_meas, right_speed_meas
// m_       out        tdata: left_duty, left_dir, right_duty, right_dir, pwm_on
// cfg_     in         write enable, register index, write data
//
// a run item raises m_tvalid after setpoint scaling and its reciprocal divide, the
// target, then nine steps per motor and the emit, which loads the output register
// a stop item raises m_tvalid after the scaling state and the emit alone; the
// next item is taken in the cycle after the emit, when the block is back in idle
// the output register holds a result while m_tready is low, and the next item is
// accepted meanwhile; a finished item waits only if the previous result is still there
// reset is synchronous and active low; per-motor state clears at once
`default_nettype none

module dual_motor_pid_speed_control_top #(
    parameter int DUTY_FULL_SCALE = dmpsc_pkg::DUTY_FULL_SCALE_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // left_speed_meas [7:0], right_speed_meas [15:8]
    input  wire logic [dmpsc_pkg::S_DATA_W-1:0] s_tdata,
    // command [0]
    input  wire logic                           s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // left_duty [9:0], left_dir [10], right_duty [20:11], right_dir [21], pwm_on [22]
    output logic [dmpsc_pkg::M_DATA_W-1:0]      m_tdata,
    input  wire logic                           cfg_we,
    input  wire logic [dmpsc_pkg::CFG_A_W-1:0]  cfg_addr,
    input  wire logic [dmpsc_pkg::CFG_D_W-1:0]  cfg_wdata
);
    import dmpsc_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer
    dmpsc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    // arithmetic and storage
    dmpsc_dp #(
        .DUTY_FULL_SCALE (DUTY_FULL_SCALE)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_cmd     (s_tuser),
        .s_data    (s_tdata),
        .m_data    (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

endmodule

`default_nettype wire

// File: bench/dmpsc_duty_checker.sv
// checker of the dual motor pid speed controller: predicts each result item and compares
// depends on dmpsc_pkg; watches the s_, m_ and cfg_ ports of the block from outside
`timescale 1ns / 100ps

module dmpsc_duty_checker #(
    parameter int FULL_SCALE = dmpsc_pkg::DUTY_FULL_SCALE_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    // left_speed_meas [7:0], right_speed_meas [15:8]
    input  wire logic [dmpsc_pkg::S_DATA_W-1:0] s_tdata,
    // command [0]
    input  wire logic                           s_tuser,
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    // left_duty [9:0], left_dir [10], right_duty [20:11], right_dir [21], pwm_on [22]
    input  wire logic [dmpsc_pkg::M_DATA_W-1:0] m_tdata,
    input  wire logic                           cfg_we,
    input  wire logic [dmpsc_pkg::CFG_A_W-1:0]  cfg_addr,
    input  wire logic [dmpsc_pkg::CFG_D_W-1:0]  cfg_wdata,
    output int                                  fail_count,
    output int                                  pending_results,
    output int                                  results_seen
);
    import dmpsc_pkg::*;

    localparam int TERM_CEIL   = 70;
    localparam int RPM_PERCENT = 100;
    localparam int RPM_BIAS    = 4;
    localparam int MAX_PRINTS  = 100;

    typedef struct packed {
        logic              pwm_on;
        logic              right_dir;
        logic [DUTY_W-1:0] right_duty;
        logic              left_dir;
        logic [DUTY_W-1:0] left_duty;
    } duty_result_t;

    // shadow registers and per-motor controller state
    logic [DUTY_W-1:0] setpoint_r;
    logic [GAIN_W-1:0] gain_p_r, gain_i_r, gain_d_r;
    logic              enable_r, left_fwd_r, right_fwd_r;
    logic [RPM_W-1:0]  last_err_r [2];
    logic [RPM_W-1:0]  err_sum_r  [2];

    duty_result_t expected_duty_q [$];
    int mismatches = 0;
    int checked    = 0;

    initial begin
        fail_count      = 0;
        pending_results = 0;
        results_seen    = 0;
    end

    // a term survives only strictly inside (0, 70) as a signed byte
    function automatic logic [RPM_W-1:0] in_band(input logic [RPM_W-1:0] t);
        int v;
        v = int'($signed(t));
        return (v > 0 && v < TERM_CEIL) ? t : '0;
    endfunction

    // one pid step of motor m; updates that motor's state
    function automatic logic [DUTY_W-1:0] predict_duty(input int m,
                                                       input logic [RPM_W-1:0] meas);
        int               sp_rpm, err_s, wide;
        logic [RPM_W-1:0] tgt, err, der, p_t, i_t, d_t, out_rpm, biased;
        sp_rpm = (int'(setpoint_r) * RPM_PERCENT) / FULL_SCALE;
        tgt    = RPM_W'(sp_rpm) - RPM_W'(RPM_BIAS);
        err    = tgt - meas;
        der    = err - last_err_r[m];
        last_err_r[m] = err;
        err_s  = int'($signed(err));
        // integral only builds up while the error stays below a tenth of the target
        if (err_s < int'(tgt) / 10)
            err_sum_r[m] = err_sum_r[m] + err;
        else
            err_sum_r[m] = '0;
        p_t = in_band(RPM_W'(int'(gain_p_r) * int'(err)));
        i_t = in_band(RPM_W'((int'(gain_i_r) * int'(err_sum_r[m])) / 10));
        d_t = in_band(RPM_W'(int'(gain_d_r) * int'(der)));
        out_rpm = tgt + p_t + i_t + d_t;
        biased  = out_rpm + RPM_W'(RPM_BIAS);
        wide    = (int'(biased) * FULL_SCALE) / RPM_PERCENT;
        if (wide > FULL_SCALE)
            wide = FULL_SCALE;
        return DUTY_W'(wide);
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        // keep the log short when everything goes wrong
        if (mismatches < MAX_PRINTS)
            $display("%0t ns: result %0d: %s expected %0d got %0d",
                     $time, checked, what, want, got);
        mismatches++;
    endtask

    // watch all three ports at each rising edge
    always @(posedge aclk) begin : watch
        duty_result_t got, want;
        if (!aresetn) begin
            setpoint_r  = RST_TARGET_SETPOINT;
            gain_p_r    = RST_GAIN_P;
            gain_i_r    = RST_GAIN_I;
            gain_d_r    = RST_GAIN_D;
            enable_r    = 1'b1;
            left_fwd_r  = 1'b0;
            right_fwd_r = 1'b1;
            for (int m = 0; m < 2; m++) begin
                last_err_r[m] = '0;
                err_sum_r[m]  = '0;
            end
            expected_duty_q.delete();
        end else begin
            // register writes; unknown indexes change nothing
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_TARGET_SETPOINT:   setpoint_r  = cfg_wdata[DUTY_W-1:0];
                    CFG_GAIN_P:            gain_p_r    = cfg_wdata[GAIN_W-1:0];
                    CFG_GAIN_I:            gain_i_r    = cfg_wdata[GAIN_W-1:0];
                    CFG_GAIN_D:            gain_d_r    = cfg_wdata[GAIN_W-1:0];
                    CFG_DRIVE_ENABLE:      enable_r    = cfg_wdata[0];
                    CFG_LEFT_DIR_FORWARD:  left_fwd_r  = cfg_wdata[0];
                    CFG_RIGHT_DIR_FORWARD: right_fwd_r = cfg_wdata[0];
                    default: ;
                endcase
            end
            // result side first: it belongs to an item taken earlier
            if (m_tvalid && m_tready) begin
                got = duty_result_t'(m_tdata[$bits(duty_result_t)-1:0]);
                if (expected_duty_q.size() == 0) begin
                    report_mismatch("result with nothing expected, tdata", 0, int'(m_tdata));
                end else begin
                    want = expected_duty_q.pop_front();
                    if (got.left_duty != want.left_duty)
                        report_mismatch("left_duty", int'(want.left_duty),
                                        int'(got.left_duty));
                    if (got.left_dir != want.left_dir)
                        report_mismatch("left_dir", int'(want.left_dir), int'(got.left_dir));
                    if (got.right_duty != want.right_duty)
                        report_mismatch("right_duty", int'(want.right_duty),
                                        int'(got.right_duty));
                    if (got.right_dir != want.right_dir)
                        report_mismatch("right_dir", int'(want.right_dir),
                                        int'(got.right_dir));
                    if (got.pwm_on != want.pwm_on)
                        report_mismatch("pwm_on", int'(want.pwm_on), int'(got.pwm_on));
                end
                checked++;
            end
            // input side: stop leaves the state alone and zeroes both duties
            if (s_tvalid && s_tready) begin
                want.left_dir  = left_fwd_r;
                want.right_dir = right_fwd_r;
                want.pwm_on    = enable_r;
                if (s_tuser) begin
                    want.left_duty  = predict_duty(0, s_tdata[RPM_W-1:0]);
                    want.right_duty = predict_duty(1, s_tdata[2*RPM_W-1:RPM_W]);
                end else begin
                    want.left_duty  = '0;
                    want.right_duty = '0;
                end
                expected_duty_q.push_back(want);
            end
        end
        fail_count      <= mismatches;
        pending_results <= expected_duty_q.size();
        results_seen    <= checked;
    end

endmodule

// File: bench/dual_motor_pid_speed_control_top_tb.sv
// testbench top of the dual motor pid speed controller: clock, reset, stimulus, verdict
// depends on dmpsc_pkg, the block's rtl and dmpsc_duty_checker
`timescale 1ns / 100ps

module dual_motor_pid_speed_control_top_tb;
    import dmpsc_pkg::*;

    localparam int  FULL_SCALE   = DUTY_FULL_SCALE_DEF;
    localparam int  HOLD_CYCLES  = 400;
    localparam int  BLOCKS       = 6;
    localparam int  BLOCK_ITEMS  = 105;
    localparam int  DRAIN_LIMIT  = 5000;
    localparam int  SETTLE       = 100;
    localparam time TIMEOUT_NS   = 10_000_000;
    localparam logic [CFG_A_W-1:0] CFG_SPARE = 3'd7;
    localparam logic CMD_STOP = 1'b0;
    localparam logic CMD_RUN  = 1'b1;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 cfg_we    = 1'b0;
    logic [CFG_A_W-1:0]   cfg_addr  = '0;
    logic [CFG_D_W-1:0]   cfg_wdata = '0;

    int fail_count, pending_results, results_seen;
    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int hold_requests = 0;
    logic hold_active = 1'b0;
    int run_items     = 0;
    int stop_items    = 0;
    int settings_used = 0;
    int cur_setpoint  = RST_TARGET_SETPOINT;
    logic leftover    = 1'b0;

    dual_motor_pid_speed_control_top #(
        .DUTY_FULL_SCALE(FULL_SCALE)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    dmpsc_duty_checker #(
        .FULL_SCALE(FULL_SCALE)
    ) duty_chk (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .results_seen    (results_seen)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // result side readiness, random unless a hold-off is running
    always @(posedge aclk) begin
        m_tready <= !hold_active && ($urandom_range(99) >= rx_idle_pct);
    end

    // long receiver hold-off, counted here so the sender keeps offering items
    initial begin : rx_hold_off
        forever begin
            @(hold_requests);
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge aclk);
            hold_active <= 1'b0;
        end
    end

    // hard stop on a hung run
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("timeout with %0d results still expected", pending_results);
        $display("Verification failed");
        $finish;
    end

    // offer one item and hold it until taken; valid stays high for a following item
    task automatic send_item(input logic cmd, input logic [RPM_W-1:0] left_meas,
                             input logic [RPM_W-1:0] right_meas);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {right_meas, left_meas};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (cmd == CMD_RUN)
            run_items++;
        else
            stop_items++;
    endtask

    // sender pauses until every result is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_A_W-1:0] idx, input int val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= CFG_D_W'(val);
        @(posedge aclk);
    endtask

    // full register set; now and then a write to the unused index as well
    task automatic apply_config(input int sp, input int gp, input int gi, input int gd,
                                input int en, input int lfwd, input int rfwd);
        write_reg(CFG_TARGET_SETPOINT, sp);
        write_reg(CFG_GAIN_P, gp);
        write_reg(CFG_GAIN_I, gi);
        write_reg(CFG_GAIN_D, gd);
        write_reg(CFG_DRIVE_ENABLE, en);
        write_reg(CFG_LEFT_DIR_FORWARD, lfwd);
        write_reg(CFG_RIGHT_DIR_FORWARD, rfwd);
        if ($urandom_range(3) == 0)
            write_reg(CFG_SPARE, $urandom_range(1023));
        cfg_we <= 1'b0;
        @(posedge aclk);
        cur_setpoint = sp;
        settings_used++;
    endtask

    function automatic int pick_gain();
        case ($urandom_range(5))
            0:       return 0;
            1:       return 255;
            2, 3:    return $urandom_range(12);
            default: return $urandom_range(255);
        endcase
    endfunction

    task automatic random_config();
        int sp;
        case ($urandom_range(9))
            0:       sp = 0;
            1:       sp = 1023;
            2:       sp = $urandom_range(60);
            default: sp = $urandom_range(1023);
        endcase
        apply_config(sp, pick_gain(), pick_gain(), pick_gain(),
                     $urandom_range(1), $urandom_range(1), $urandom_range(1));
    endtask

    // speed readings mostly close to the target so the integral path gets exercised
    function automatic logic [RPM_W-1:0] pick_speed();
        logic [RPM_W-1:0] nominal;
        nominal = RPM_W'((cur_setpoint * 100) / FULL_SCALE) - 8'd4;
        if ($urandom_range(2) != 0)
            return nominal + RPM_W'($urandom_range(40)) - 8'd20;
        return RPM_W'($urandom_range(255));
    endfunction

    task automatic send_random_item();
        logic cmd;
        cmd = ($urandom_range(99) < 85) ? CMD_RUN : CMD_STOP;
        send_item(cmd, pick_speed(), pick_speed());
    endtask

    initial begin : stimulus
        int n;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset settings, stop, extreme readings, readings at the target
        send_item(CMD_STOP, 8'd255, 8'd255);
        send_item(CMD_RUN,  8'd0,   8'd0);
        send_item(CMD_RUN,  8'd255, 8'd255);
        send_item(CMD_RUN,  8'd55,  8'd55);
        send_item(CMD_RUN,  8'd50,  8'd60);
        send_item(CMD_RUN,  8'd54,  8'd56);
        send_item(CMD_RUN,  8'd200, 8'd10);
        send_item(CMD_STOP, 8'd0,   8'd0);
        send_item(CMD_RUN,  8'd53,  8'd57);
        wait_drained();
        // full setpoint, maximum gains, drive off, directions swapped
        apply_config(1023, 255, 255, 255, 0, 1, 0);
        send_item(CMD_RUN,  8'd0,   8'd255);
        send_item(CMD_RUN,  8'd96,  8'd96);
        send_item(CMD_RUN,  8'd100, 8'd0);
        send_item(CMD_STOP, 8'd170, 8'd85);
        wait_drained();
        // zero setpoint: the target wraps round, gains off
        apply_config(0, 0, 0, 0, 1, 0, 0);
        send_item(CMD_RUN,  8'd0,   8'd0);
        send_item(CMD_RUN,  8'd252, 8'd252);
        send_item(CMD_RUN,  8'd255, 8'd128);
        wait_drained();
        // setpoint just under four rpm, small gains
        apply_config(40, 1, 10, 1, 1, 1, 1);
        send_item(CMD_RUN,  8'd0,   8'd0);
        send_item(CMD_RUN,  8'd127, 8'd128);
        send_item(CMD_RUN,  8'd255, 8'd1);
        send_item(CMD_RUN,  8'd254, 8'd254);
        wait_drained();

        // random part over three idling schemes
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin tx_idle_pct = 9;  rx_idle_pct <= 88; end
                1: begin tx_idle_pct = 88; rx_idle_pct <= 9;  end
                default: begin tx_idle_pct = 0; rx_idle_pct <= 0; end
            endcase
            for (int blk = 0; blk < BLOCKS; blk++) begin
                random_config();
                for (int k = 0; k < BLOCK_ITEMS; k++) begin
                    if (blk == 2 && k == 40)
                        hold_requests <= hold_requests + 1;
                    send_random_item();
                end
                wait_drained();
            end
        end

        // final drain with a limit, then a quiet tail
        s_tvalid <= 1'b0;
        @(posedge aclk);
        n = 0;
        while (pending_results != 0 && n < DRAIN_LIMIT) begin
            @(posedge aclk);
            n++;
        end
        leftover = (pending_results != 0);
        if (leftover)
            $display("%0d results still expected at the end", pending_results);
        repeat (SETTLE) @(posedge aclk);

        $display("covered %0d items (%0d run, %0d stop), %0d results compared",
                 run_items + stop_items, run_items, stop_items, results_seen);
        $display("over %0d register settings, three idling schemes and %0d hold-offs",
                 settings_used, hold_requests);
        if (fail_count == 0 && !leftover)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
